// ===== rtl/core/csvt_pkg.sv =====
// csvt_pkg: shared types and constants of the csv cell tokenizer
// used by csvt_chain, csv_cell_tokenizer and tb_top; depends on nothing
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] BOM_B0   = 8'hEF;
    localparam logic [7:0] BOM_B1   = 8'hBB;
    localparam logic [7:0] BOM_B2   = 8'hBF;

    localparam logic [1:0] QSAT_MAX = 2'd3;
    localparam logic [1:0] BOM_LAST = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // write request into the cell chain
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_byte;
        logic       bom_fill;
        logic       bom_two;
    } chain_wr_t;

    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = BOM_B0;
            2'd1:    b = BOM_B1;
            2'd2:    b = BOM_B2;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/csvt_cell.sv =====
// csvt_cell: one byte cell of the cell buffer chain
// loads a new byte or takes its right neighbor's byte; no package use
module csvt_cell (
    input  logic       clk,
    input  logic       load,
    input  logic [7:0] load_data,
    input  logic       shift,
    input  logic [7:0] shift_data,
    output logic [7:0] data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (shift)
        begin
            data_next = shift_data;
        end
        else if (load)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/core/csvt_chain.sv =====
// csvt_chain: row of csvt_cell holding the current cell's bytes
// writes land at one index and mark fills in cells 0 and 1; a drain shifts
// every byte one cell toward the head; depends on csvt_pkg and csvt_cell
module csvt_chain
    import csvt_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  chain_wr_t        wr,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             shift,
    output logic [7:0]       head0,
    output logic [7:0]       head1
);

    logic [7:0] cell_data [DEPTH];
    logic [7:0] nbr_data  [DEPTH];
    logic       cell_load [DEPTH];
    logic [7:0] cell_ldat [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr_data[i] = 8'h00;
        end
        else
        begin : g_mid
            assign nbr_data[i] = cell_data[i+1];
        end

        // partial byte order mark bytes go to the first two cells
        always_comb
        begin
            cell_load[i] = 1'b0;
            cell_ldat[i] = wr.wr_byte;
            if (wr.wr_en && wr_idx == IDX_W'(i))
            begin
                cell_load[i] = 1'b1;
            end
            else if (wr.bom_fill && i == 0)
            begin
                cell_load[i] = 1'b1;
                cell_ldat[i] = BOM_B0;
            end
            else if (wr.bom_fill && wr.bom_two && i == 1)
            begin
                cell_load[i] = 1'b1;
                cell_ldat[i] = BOM_B1;
            end
        end

        csvt_cell u_cell (
            .clk        (clk),
            .load       (cell_load[i]),
            .load_data  (cell_ldat[i]),
            .shift      (shift),
            .shift_data (nbr_data[i]),
            .data       (cell_data[i])
        );
    end

    assign head0 = cell_data[0];
    assign head1 = cell_data[1];

endmodule

// ===== rtl/core/csv_cell_tokenizer.sv =====
// csv_cell_tokenizer: one text byte per cycle while idle; a byte that ends a cell
// starts a drain of the cell chain that shifts out its beats, dropping a stripped
// leading byte and the second quote of each collapsed pair; input stalls meanwhile
// an empty cell drains as a single marker beat with byte_valid low; a cell's beats
// pass through the drain state into the output registers, held by output stalls
// reset clears all control state and rearms the byte order mark check, not the buffer
module csv_cell_tokenizer
    import csvt_pkg::*;
#(
    parameter int CELL_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       stream_start,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       cell_last,
    output logic       row_last,
    output logic       cell_overflow
);

    localparam int LEN_W = $clog2(CELL_DEPTH + 1);
    localparam int IDX_W = $clog2(CELL_DEPTH);

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       qsat_reg, qsat_next;
    logic             par_reg, par_next;
    logic             lwq_reg, lwq_next;
    logic             ovf_reg, ovf_next;
    logic [1:0]       bom_pos_reg, bom_pos_next;
    logic             bom_match_reg, bom_match_next;

    logic [LEN_W-1:0] dr_idx_reg, dr_idx_next;
    logic [LEN_W-1:0] dr_end_reg, dr_end_next;
    logic             dr_start_reg, dr_start_next;
    logic             dr_collapse_reg, dr_collapse_next;
    logic             dr_row_reg, dr_row_next;
    logic             dr_ovf_reg, dr_ovf_next;
    logic             dr_empty_reg, dr_empty_next;
    logic             dr_skip_reg, dr_skip_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             byte_valid_reg, byte_valid_next;
    logic             cell_last_reg, cell_last_next;
    logic             row_last_reg, row_last_next;
    logic             cell_ovf_reg, cell_ovf_next;
    logic             out_load;

    // cell state as seen by the incoming byte, after a stream start
    logic [LEN_W-1:0] eff_len;
    logic [1:0]       eff_qsat;
    logic             eff_par;
    logic             eff_lwq;
    logic             eff_ovf;
    logic [1:0]       eff_pos;
    logic             eff_bm;
    logic             bom_hit;
    logic             bom_flush;
    logic [LEN_W-1:0] base_len;
    logic             is_quote;
    logic             is_sep;
    logic             cell_end;
    logic             strip;
    logic [LEN_W-1:0] ent_end;
    logic             ent_start;

    logic [LEN_W:0]   pos_plus1;
    logic [LEN_W:0]   pos_next;
    logic             dbl;
    logic             last_beat;
    logic             out_ok;

    chain_wr_t        wr;
    logic [IDX_W-1:0] wr_idx;
    logic             shift;
    logic [7:0]       head0;
    logic [7:0]       head1;

    csvt_chain #(
        .DEPTH (CELL_DEPTH)
    ) u_chain (
        .clk    (clk),
        .wr     (wr),
        .wr_idx (wr_idx),
        .shift  (shift),
        .head0  (head0),
        .head1  (head1)
    );

    always_comb
    begin
        eff_len  = stream_start ? '0 : len_reg;
        eff_qsat = stream_start ? 2'd0 : qsat_reg;
        eff_par  = stream_start ? 1'b0 : par_reg;
        eff_lwq  = stream_start ? 1'b0 : lwq_reg;
        eff_ovf  = stream_start ? 1'b0 : ovf_reg;
        eff_pos  = stream_start ? 2'd0 : bom_pos_reg;
        eff_bm   = stream_start ? 1'b1 : bom_match_reg;

        bom_hit   = eff_bm && eff_pos != 2'd3 && in_byte == bom_byte(eff_pos);
        bom_flush = eff_bm && eff_pos != 2'd0;
        // the cell is empty while the mark is still being matched
        base_len  = bom_flush ? LEN_W'(eff_pos) : eff_len;

        is_quote = in_byte == CH_QUOTE;
        is_sep   = in_byte == CH_COMMA || in_byte == CH_NL;
        cell_end = is_sep && (eff_qsat == 2'd0 || (eff_lwq && !eff_par));

        strip     = eff_qsat >= 2'd2;
        ent_end   = (strip && base_len != '0) ? base_len - LEN_W'(1) : base_len;
        ent_start = strip && ent_end != '0;

        pos_plus1 = {1'b0, dr_idx_reg} + (LEN_W+1)'(1);
        dbl       = dr_collapse_reg && head0 == CH_QUOTE && head1 == CH_QUOTE
                    && pos_plus1 < {1'b0, dr_end_reg};
        pos_next  = pos_plus1 + (LEN_W+1)'(dbl);
        last_beat = pos_next >= {1'b0, dr_end_reg};
        out_ok    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        qsat_next        = qsat_reg;
        par_next         = par_reg;
        lwq_next         = lwq_reg;
        ovf_next         = ovf_reg;
        bom_pos_next     = bom_pos_reg;
        bom_match_next   = bom_match_reg;
        dr_idx_next      = dr_idx_reg;
        dr_end_next      = dr_end_reg;
        dr_start_next    = dr_start_reg;
        dr_collapse_next = dr_collapse_reg;
        dr_row_next      = dr_row_reg;
        dr_ovf_next      = dr_ovf_reg;
        dr_empty_next    = dr_empty_reg;
        dr_skip_next     = dr_skip_reg;
        wr               = '0;
        wr_idx           = base_len[IDX_W-1:0];
        shift            = 1'b0;
        out_load         = 1'b0;
        out_byte_next    = out_byte_reg;
        byte_valid_next  = byte_valid_reg;
        cell_last_next   = cell_last_reg;
        row_last_next    = row_last_reg;
        cell_ovf_next    = cell_ovf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    len_next       = eff_len;
                    qsat_next      = eff_qsat;
                    par_next       = eff_par;
                    lwq_next       = eff_lwq;
                    ovf_next       = eff_ovf;
                    bom_pos_next   = eff_pos;
                    bom_match_next = eff_bm;
                    if (bom_hit)
                    begin
                        bom_pos_next   = (eff_pos == BOM_LAST) ? 2'd0 : eff_pos + 2'd1;
                        bom_match_next = eff_pos != BOM_LAST;
                    end
                    else
                    begin
                        bom_pos_next   = 2'd0;
                        bom_match_next = 1'b0;
                        wr.bom_fill    = bom_flush;
                        wr.bom_two     = eff_pos == BOM_LAST;
                        if (!is_quote && cell_end)
                        begin
                            dr_idx_next      = '0;
                            dr_end_next      = ent_end;
                            dr_start_next    = ent_start;
                            dr_collapse_next = eff_qsat == QSAT_MAX;
                            dr_row_next      = in_byte == CH_NL;
                            dr_ovf_next      = eff_ovf;
                            dr_empty_next    = ent_end <= LEN_W'(ent_start);
                            dr_skip_next     = 1'b0;
                            state_next       = ST_DRAIN;
                            len_next         = '0;
                            qsat_next        = 2'd0;
                            par_next         = 1'b0;
                            lwq_next         = 1'b0;
                            ovf_next         = 1'b0;
                        end
                        else
                        begin
                            if (is_quote)
                            begin
                                qsat_next = (eff_qsat == QSAT_MAX) ? QSAT_MAX
                                                                   : eff_qsat + 2'd1;
                                par_next  = !eff_par;
                            end
                            lwq_next = is_quote;
                            if (base_len < LEN_W'(CELL_DEPTH))
                            begin
                                wr.wr_en   = 1'b1;
                                wr.wr_byte = in_byte;
                                len_next   = base_len + LEN_W'(1);
                            end
                            else
                            begin
                                len_next = base_len;
                                ovf_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (dr_empty_reg)
                begin
                    if (out_ok)
                    begin
                        out_load        = 1'b1;
                        out_byte_next   = 8'h00;
                        byte_valid_next = 1'b0;
                        cell_last_next  = 1'b1;
                        row_last_next   = dr_row_reg;
                        cell_ovf_next   = dr_ovf_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else if (dr_skip_reg || (dr_start_reg && dr_idx_reg == '0))
                begin
                    // drop the second quote of a pair or the stripped opening byte
                    shift        = 1'b1;
                    dr_idx_next  = dr_idx_reg + LEN_W'(1);
                    dr_skip_next = 1'b0;
                end
                else if (out_ok)
                begin
                    out_load        = 1'b1;
                    out_byte_next   = head0;
                    byte_valid_next = 1'b1;
                    cell_last_next  = last_beat;
                    row_last_next   = last_beat && dr_row_reg;
                    cell_ovf_next   = dr_ovf_reg;
                    if (last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        shift        = 1'b1;
                        dr_idx_next  = dr_idx_reg + LEN_W'(1);
                        dr_skip_next = dbl;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            len_reg         <= '0;
            qsat_reg        <= 2'd0;
            par_reg         <= 1'b0;
            lwq_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            bom_pos_reg     <= 2'd0;
            bom_match_reg   <= 1'b1;
            dr_idx_reg      <= '0;
            dr_end_reg      <= '0;
            dr_start_reg    <= 1'b0;
            dr_collapse_reg <= 1'b0;
            dr_row_reg      <= 1'b0;
            dr_ovf_reg      <= 1'b0;
            dr_empty_reg    <= 1'b0;
            dr_skip_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            qsat_reg        <= qsat_next;
            par_reg         <= par_next;
            lwq_reg         <= lwq_next;
            ovf_reg         <= ovf_next;
            bom_pos_reg     <= bom_pos_next;
            bom_match_reg   <= bom_match_next;
            dr_idx_reg      <= dr_idx_next;
            dr_end_reg      <= dr_end_next;
            dr_start_reg    <= dr_start_next;
            dr_collapse_reg <= dr_collapse_next;
            dr_row_reg      <= dr_row_next;
            dr_ovf_reg      <= dr_ovf_next;
            dr_empty_reg    <= dr_empty_next;
            dr_skip_reg     <= dr_skip_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        cell_last_reg  <= cell_last_next;
        row_last_reg   <= row_last_next;
        cell_ovf_reg   <= cell_ovf_next;
    end

    assign in_stall      = state_reg != ST_IDLE;
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign cell_last     = cell_last_reg;
    assign row_last      = row_last_reg;
    assign cell_overflow = cell_ovf_reg;

`ifndef SYNTHESIS
    // the chain is never written while it is being drained
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> !wr.wr_en && !wr.bom_fill)
        else $error("cell chain written during drain");

    // a non-empty drain always points inside the cell
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN && !dr_empty_reg |-> dr_idx_reg < dr_end_reg)
        else $error("drain index past cell end");

    // an empty-cell marker beat closes its cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> cell_last && out_byte == 8'h00)
        else $error("empty cell marker without cell_last");

    // row end only on the closing beat of a cell
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_last |-> cell_last)
        else $error("row_last without cell_last");
`endif

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for csv_cell_tokenizer, with directed and random csv text
// depends on csvt_pkg for the character and byte order mark constants and on the rtl top
module tb_top;
    import csvt_pkg::*;

    localparam int          CELL_DEPTH = 64;
    localparam int          IDX_W      = $clog2(CELL_DEPTH);
    localparam int          TEXT_ITEMS = 350;
    localparam int          CALM_FROM  = 150;
    localparam int          CALM_TO    = 260;
    localparam logic [23:0] MARK_SEQ   = {BOM_B2, BOM_B1, BOM_B0};

    typedef struct packed {
        logic [7:0] data;
        logic       bvalid;
        logic       clast;
        logic       rlast;
        logic       ovf;
    } cell_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       calm;
    } text_item_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic [7:0] in_byte      = 8'h00;
    logic       stream_start = 1'b0;
    logic       out_stall    = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       cell_last;
    logic       row_last;
    logic       cell_overflow;

    csv_cell_tokenizer #(.CELL_DEPTH(CELL_DEPTH)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .stream_start  (stream_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .cell_last     (cell_last),
        .row_last      (row_last),
        .cell_overflow (cell_overflow)
    );

    always #5 clk = ~clk;

    text_item_t text_q[$];
    cell_beat_t cell_beats_q[$];
    text_item_t next_item;
    logic       start_pending = 1'b0;
    logic       calm_now      = 1'b0;
    int         items_taken   = 0;
    int         items_total   = 0;
    int         errors        = 0;
    int         beats_seen    = 0;
    int         cells_seen    = 0;
    int         rows_seen     = 0;
    int         ovf_cells     = 0;

    // tokenizer state as the block should hold it
    logic [7:0]  cell_mem [CELL_DEPTH];
    int unsigned cell_len    = 0;
    logic [1:0]  quote_tally = 2'd0;
    logic        quote_odd   = 1'b0;
    logic        prev_quote  = 1'b0;
    logic        lost_bytes  = 1'b0;
    logic [1:0]  mark_pos    = 2'd0;
    logic        mark_armed  = 1'b1;

    function automatic void open_cell();
        cell_len    = 0;
        quote_tally = 2'd0;
        quote_odd   = 1'b0;
        prev_quote  = 1'b0;
        lost_bytes  = 1'b0;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        if (cell_len < CELL_DEPTH)
        begin
            cell_mem[IDX_W'(cell_len)] = b;
            cell_len++;
        end
        else
            lost_bytes = 1'b1;
        prev_quote = (b == CH_QUOTE);
    endfunction

    function automatic void finish_cell(input logic nl);
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        int unsigned n;
        logic        squeeze;
        cell_beat_t  beat;
        lo      = 0;
        hi      = cell_len;
        n       = 0;
        squeeze = (quote_tally == QSAT_MAX);
        // quoted cell: the enclosing bytes go
        if (quote_tally >= 2'd2 && hi > 0)
        begin
            hi = hi - 1;
            if (hi > 0)
                lo = 1;
        end
        i = lo;
        while (i < hi)
        begin
            beat.data   = cell_mem[IDX_W'(i)];
            beat.bvalid = 1'b1;
            beat.clast  = 1'b0;
            beat.rlast  = 1'b0;
            beat.ovf    = lost_bytes;
            if (squeeze && cell_mem[IDX_W'(i)] == CH_QUOTE && i + 1 < hi &&
                cell_mem[IDX_W'(i + 1)] == CH_QUOTE)
                i += 2;
            else
                i += 1;
            if (i >= hi)
            begin
                beat.clast = 1'b1;
                beat.rlast = nl;
            end
            cell_beats_q.insert(cell_beats_q.size(), beat);
            n++;
        end
        if (n == 0)
        begin
            beat.data   = 8'h00;
            beat.bvalid = 1'b0;
            beat.clast  = 1'b1;
            beat.rlast  = nl;
            beat.ovf    = lost_bytes;
            cell_beats_q.insert(cell_beats_q.size(), beat);
        end
        open_cell();
    endfunction

    function automatic void predict_text_byte(input logic [7:0] b, input logic first);
        int unsigned matched;
        if (first)
        begin
            open_cell();
            mark_pos   = 2'd0;
            mark_armed = 1'b1;
        end
        if (mark_armed)
        begin
            matched = mark_pos;
            if (b == MARK_SEQ[matched * 8 +: 8])
            begin
                if (mark_pos == BOM_LAST)
                begin
                    mark_armed = 1'b0;
                    mark_pos   = 2'd0;
                end
                else
                    mark_pos = mark_pos + 2'd1;
                return;
            end
            mark_armed = 1'b0;
            mark_pos   = 2'd0;
            // partial mark falls back into the cell as data
            for (int k = 0; k < matched; k++)
                store_byte(MARK_SEQ[k * 8 +: 8]);
        end
        if (b == CH_QUOTE)
        begin
            if (quote_tally != QSAT_MAX)
                quote_tally = quote_tally + 2'd1;
            quote_odd = ~quote_odd;
        end
        else if ((b == CH_COMMA || b == CH_NL) &&
                 (quote_tally == 2'd0 || (prev_quote && !quote_odd)))
        begin
            finish_cell(b == CH_NL);
            return;
        end
        store_byte(b);
    endfunction

    // text generation
    function automatic void push_text(input logic [7:0] b);
        text_item_t it;
        it.data       = b;
        it.first      = start_pending;
        it.calm       = (text_q.size() >= CALM_FROM && text_q.size() < CALM_TO);
        start_pending = 1'b0;
        text_q.insert(text_q.size(), it);
    endfunction

    function automatic void push_string(input string s);
        for (int k = 0; k < s.len(); k++)
            push_text(s[k]);
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_QUOTE || c == CH_COMMA || c == CH_NL);
        return c;
    endfunction

    function automatic void begin_text();
        int unsigned m;
        start_pending = 1'b1;
        m = $urandom_range(5);
        if (m <= 2)
            push_text(BOM_B0);
        if (m == 0 || m == 2)
            push_text(BOM_B1);
        if (m == 0)
            push_text(BOM_B2);
    endfunction

    function automatic void add_plain(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            push_text(plain_char());
    endfunction

    function automatic void add_quoted(input int unsigned len);
        int unsigned sel;
        push_text(CH_QUOTE);
        for (int unsigned k = 0; k < len; k++)
        begin
            sel = $urandom_range(19);
            if (sel < 3)
            begin
                push_text(CH_QUOTE);
                push_text(CH_QUOTE);
            end
            else if (sel < 5)
                push_text(CH_COMMA);
            else if (sel < 7)
                push_text(CH_NL);
            else
                push_text(plain_char());
        end
        push_text(CH_QUOTE);
    endfunction

    function automatic void add_noise(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
        begin
            case ($urandom_range(5))
                0:       push_text(CH_QUOTE);
                1:       push_text(CH_COMMA);
                2:       push_text(CH_NL);
                default: push_text(8'($urandom_range(255)));
            endcase
        end
    endfunction

    function automatic void add_row();
        int unsigned cells;
        int unsigned kind;
        cells = $urandom_range(1, 4);
        for (int unsigned c = 0; c < cells; c++)
        begin
            kind = $urandom_range(19);
            // kinds below three leave the cell empty
            if (kind >= 3)
            begin
                if (kind < 10)
                    add_plain($urandom_range(1, 6));
                else if (kind < 16)
                    add_quoted($urandom_range(0, 6));
                else if (kind < 19)
                    add_noise($urandom_range(1, 4));
                else if ($urandom_range(3) == 0)
                    add_plain($urandom_range(60, 72));
                else
                    add_plain(2);
            end
            if (c + 1 < cells)
                push_text(CH_COMMA);
        end
        // now and then a row stays open and the next text drops it
        if ($urandom_range(11) != 0)
            push_text(CH_NL);
        else
            begin_text();
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic check_beat();
        cell_beat_t got;
        cell_beat_t want;
        got.data   = out_byte;
        got.bvalid = byte_valid;
        got.clast  = cell_last;
        got.rlast  = row_last;
        got.ovf    = cell_overflow;
        beats_seen++;
        if (got.clast)
        begin
            cells_seen++;
            if (got.rlast)
                rows_seen++;
            if (got.ovf)
                ovf_cells++;
        end
        if (cell_beats_q.size() == 0)
            note_failure($sformatf("unexpected beat: byte=%02h v=%b cl=%b rl=%b ovf=%b",
                got.data, got.bvalid, got.clast, got.rlast, got.ovf));
        else
        begin
            want = cell_beats_q.pop_front();
            if (got !== want)
                note_failure($sformatf(
                    {"beat %0d mismatch: exp byte=%02h v=%b cl=%b rl=%b ovf=%b,",
                     " got byte=%02h v=%b cl=%b rl=%b ovf=%b"},
                    beats_seen, want.data, want.bvalid, want.clast, want.rlast, want.ovf,
                    got.data, got.bvalid, got.clast, got.rlast, got.ovf));
        end
    endtask

    // input driver: one text byte per beat, random gaps outside the calm stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_text_byte(in_byte, stream_start);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (text_q.size() != 0 && (text_q[0].calm || $urandom_range(99) >= 9))
                begin
                    next_item = text_q.pop_front();
                    in_valid     <= 1'b1;
                    in_byte      <= next_item.data;
                    stream_start <= next_item.first;
                    calm_now     <= next_item.calm;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and back pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
                check_beat();
            out_stall <= !calm_now && ($urandom_range(99) < 9);
        end
    end

    initial
    begin
        // directed: full mark, partial mark, doubled quotes, quoted comma, cr and byte extremes
        start_pending = 1'b1;
        push_text(BOM_B0);
        push_text(BOM_B1);
        push_text(BOM_B2);
        push_string("a,\n");
        start_pending = 1'b1;
        push_text(BOM_B0);
        push_text(BOM_B1);
        push_string("x,");
        push_string("\"a\"\"b\",");
        push_string("\"x,y\"\n");
        push_text(8'h00);
        push_text(8'hFF);
        push_string("\r\n");
        push_string("zz");
        // overflow of a plain and of a quoted cell
        start_pending = 1'b1;
        add_plain(68);
        push_text(CH_COMMA);
        add_quoted(66);
        push_text(CH_NL);
        while (text_q.size() < TEXT_ITEMS)
        begin
            if ($urandom_range(7) == 0)
                begin_text();
            add_row();
        end
        items_total = text_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (items_taken != items_total)
            @(posedge clk);
        while (cell_beats_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("run covered %0d text bytes, %0d beats in %0d cells over %0d rows",
            items_taken, beats_seen, cells_seen, rows_seen);
        $display("%0d cells overflowed, %0d mismatches", ovf_cells, errors);
        if (errors == 0)
            $display("[csv_cell_tokenizer] OK");
        else
            $display("[csv_cell_tokenizer] ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("[csv_cell_tokenizer] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/csvt_pkg.sv
rtl/core/csvt_cell.sv
rtl/core/csvt_chain.sv
rtl/core/csv_cell_tokenizer.sv
tb/tb_top.sv
